// ===== design/xlc_pkg.sv =====
package xlc_pkg;

  // Default size of the cube-root table.
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned CH_W      = 16;
  localparam int unsigned OUT_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

  // Reset values of the white point (D65, unsigned Q8.8).
  localparam logic [CH_W-1:0] WHITE_X_RST = 16'd24332;
  localparam logic [CH_W-1:0] WHITE_Y_RST = 16'd25600;
  localparam logic [CH_W-1:0] WHITE_Z_RST = 16'd27874;

  // Integer cube root by binary search, used only to build the table.
  function automatic longint unsigned icbrt(input longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

endpackage

// ===== design/xlc_lane.sv =====
module xlc_lane #(
  parameter int unsigned TableEntries = xlc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned QW = 32 + $clog2(TableEntries + 1),
  localparam int unsigned FW = QW + 2
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic        [xlc_pkg::CH_W-1:0] chan_i,
  input  logic        [xlc_pkg::CH_W-1:0] white_i,
  output logic signed [FW-1:0]         f_o
);

  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned IW = QW - 16;

  // Constant cube-root table, linear segment near black.
  logic [16:0] rom_w [TableEntries];

  for (genvar gi = 0; gi < TableEntries; gi++) begin : g_rom
    localparam longint unsigned GI  = gi;
    localparam longint unsigned NN  = TableEntries;
    localparam longint unsigned NUM = (903292 * GI + 16000 * NN) * 65536 + 58000 * NN;
    localparam longint unsigned LIN = NUM / (116000 * NN);
    localparam longint unsigned CBR = xlc_pkg::icbrt((GI << 48) / NN);
    localparam longint unsigned VAL = (GI * 1000000 < 8856 * NN) ? LIN : CBR;
    assign rom_w[gi] = VAL[16:0];
  end

  // Restoring divider, one quotient bit per stage.
  logic [QW-1:0] num_q [QW+1];
  logic [15:0]   rem_q [QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= QW'((64'(chan_i) * 64'(TableEntries)) << 16);
      rem_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [16:0] t;
    logic        ge;
    assign t  = {rem_q[k], num_q[k][QW-1]};
    assign ge = t >= {1'b0, white_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= {num_q[k][QW-2:0], ge};
      end
    end
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? 16'(t - {1'b0, white_i}) : t[15:0];
        end
      end
    end
  end

  // Table index clamped to the last pair, fraction left unclamped.
  logic [IW-1:0] idx;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr1;
  logic [QW-1:0] frac;

  assign idx   = num_q[QW][QW-1:16];
  assign addr  = (idx > IW'(TableEntries - 2)) ? AW'(TableEntries - 2) : idx[AW-1:0];
  assign addr1 = addr + AW'(1);
  assign frac  = num_q[QW] - (QW'(addr) << 16);

  logic [16:0]   e0_q;
  logic [16:0]   e1_q;
  logic [QW-1:0] frac_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q   <= rom_w[addr];
      e1_q   <= rom_w[addr1];
      frac_q <= frac;
    end
  end

  logic signed [17:0]   diff_raw;
  logic signed [15:0]   diff;
  logic signed [QW+16:0] prod;

  assign diff_raw = $signed({1'b0, e1_q}) - $signed({1'b0, e0_q});
  assign diff = (diff_raw > 18'sd16384)  ? 16'sd16384 :
                (diff_raw < -18'sd16384) ? -16'sd16384 : diff_raw[15:0];
  assign prod = $signed({1'b0, frac_q}) * diff;

  logic signed [QW+16:0] prod_q;
  logic        [16:0]    e0p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
      e0p_q  <= e0_q;
    end
  end

  logic signed [FW-1:0] f_d;
  logic signed [FW-1:0] f_q;

  assign f_d = $signed({{(FW-17){1'b0}}, e0p_q}) + FW'(prod_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign f_o = f_q;

endmodule

// ===== design/xlc_merge.sv =====
module xlc_merge #(
  parameter int unsigned FW = 47
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [FW-1:0]             fx_i,
  input  logic signed [FW-1:0]             fy_i,
  input  logic signed [FW-1:0]             fz_i,
  output logic signed [xlc_pkg::OUT_W-1:0] l_o,
  output logic signed [xlc_pkg::OUT_W-1:0] a_o,
  output logic signed [xlc_pkg::OUT_W-1:0] b_o
);

  localparam int unsigned MW = FW + 11;

  function automatic logic signed [xlc_pkg::OUT_W-1:0] sat_round(
    input logic signed [MW-1:0] v
  );
    logic signed [MW-1:0] r;
    r = (v + MW'(128)) >>> 8;
    if (r > MW'(524287)) begin
      return 20'sh7FFFF;
    end else if (r < MW'(-524288)) begin
      return 20'sh80000;
    end
    return r[xlc_pkg::OUT_W-1:0];
  endfunction

  logic signed [MW-1:0] fx_e;
  logic signed [MW-1:0] fy_e;
  logic signed [MW-1:0] fz_e;
  logic signed [MW-1:0] l_d;
  logic signed [MW-1:0] a_d;
  logic signed [MW-1:0] b_d;
  logic signed [MW-1:0] l_q;
  logic signed [MW-1:0] a_q;
  logic signed [MW-1:0] b_q;

  assign fx_e = MW'(fx_i);
  assign fy_e = MW'(fy_i);
  assign fz_e = MW'(fz_i);
  assign l_d  = fy_e * MW'(116) - MW'(1048576);
  assign a_d  = (fx_e - fy_e) * MW'(500);
  assign b_d  = (fy_e - fz_e) * MW'(200);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
      l_o <= sat_round(l_q);
      a_o <= sat_round(a_q);
      b_o <= sat_round(b_q);
    end
  end

endmodule

// ===== design/xyz_to_lab_converter_unit.sv =====
// XYZ to Lab converter.
// Input channel: x_in_i, y_in_i, z_in_i (unsigned Q8.8) with in_valid_i and
// in_stall_o. A transaction takes place at a rising edge with valid high and
// stall low. Output channel: l_out_o, a_out_o, b_out_o (signed Q11.8,
// saturated) with out_valid_o and out_stall_i, same rule.
// The configuration channel writes the reference white: cfg_index_i selects
// white X, Y or Z (indexes 0 to 2, others are ignored), cfg_data_i carries the
// value, and a transaction completes when cfg_valid_i and cfg_ready_o are high.
// Write it only while no pixel is in flight. A white of zero acts as one.
// Three identical lanes each divide one channel by its white and interpolate
// the cube-root table; a merge stage forms L, a and b.
// Throughput is one pixel per clock while the output is not stalled. The
// quotient width of the pipelined divider is 32 + clog2(TABLE_ENTRIES + 1).
// Reset clears all valid flags and loads the D65 white point. When the
// receiver stalls with a result waiting, the whole pipeline holds and the
// input channel stalls in the same cycle.
module xyz_to_lab_converter_unit #(
  parameter int unsigned TABLE_ENTRIES = xlc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [xlc_pkg::CH_W-1:0]      x_in_i,
  input  logic        [xlc_pkg::CH_W-1:0]      y_in_i,
  input  logic        [xlc_pkg::CH_W-1:0]      z_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [xlc_pkg::OUT_W-1:0]     l_out_o,
  output logic signed [xlc_pkg::OUT_W-1:0]     a_out_o,
  output logic signed [xlc_pkg::OUT_W-1:0]     b_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [xlc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [xlc_pkg::CH_W-1:0]      cfg_data_i
);

  // Quotient width of the divider and width of an interpolated value.
  localparam int unsigned QW  = 32 + $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned FW  = QW + 2;
  localparam int unsigned LAT = QW + 6;

  // Reference white registers. The port is always ready since a write is
  // stored directly in its register.
  logic [xlc_pkg::CH_W-1:0] white_x_q;
  logic [xlc_pkg::CH_W-1:0] white_y_q;
  logic [xlc_pkg::CH_W-1:0] white_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= xlc_pkg::WHITE_X_RST;
      white_y_q <= xlc_pkg::WHITE_Y_RST;
      white_z_q <= xlc_pkg::WHITE_Z_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        xlc_pkg::REG_WHITE_X: white_x_q <= cfg_data_i;
        xlc_pkg::REG_WHITE_Y: white_y_q <= cfg_data_i;
        xlc_pkg::REG_WHITE_Z: white_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero divisor is treated as one.
  logic [xlc_pkg::CH_W-1:0] wx;
  logic [xlc_pkg::CH_W-1:0] wy;
  logic [xlc_pkg::CH_W-1:0] wz;

  assign wx = (white_x_q == '0) ? xlc_pkg::CH_W'(1) : white_x_q;
  assign wy = (white_y_q == '0) ? xlc_pkg::CH_W'(1) : white_y_q;
  assign wz = (white_z_q == '0) ? xlc_pkg::CH_W'(1) : white_z_q;

  // The pipeline moves as one unit; it holds only when a finished result is
  // being stalled at the output register. Bubbles flow through freely.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // One lane per tristimulus channel.
  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;
  logic signed [FW-1:0] fz;

  xlc_lane #(.TableEntries(TABLE_ENTRIES)) u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (x_in_i),
    .white_i(wx),
    .f_o    (fx)
  );

  xlc_lane #(.TableEntries(TABLE_ENTRIES)) u_lane_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (y_in_i),
    .white_i(wy),
    .f_o    (fy)
  );

  xlc_lane #(.TableEntries(TABLE_ENTRIES)) u_lane_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (z_in_i),
    .white_i(wz),
    .f_o    (fz)
  );

  // Combine the three lanes into L, a and b, then round and saturate.
  xlc_merge #(.FW(FW)) u_merge (
    .clk_i(clk_i),
    .en_i (en),
    .fx_i (fx),
    .fy_i (fy),
    .fz_i (fz),
    .l_o  (l_out_o),
    .a_o  (a_out_o),
    .b_o  (b_out_o)
  );

endmodule

// ===== tb/tb_xyz_to_lab_converter_checker.sv =====
module tb_xyz_to_lab_converter_checker
  import xlc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CH_W-1:0]        x_in_i,
  input  logic [CH_W-1:0]        y_in_i,
  input  logic [CH_W-1:0]        z_in_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [OUT_W-1:0] l_out_i,
  input  logic signed [OUT_W-1:0] a_out_i,
  input  logic signed [OUT_W-1:0] b_out_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CH_W-1:0]        cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] l;
    logic [OUT_W-1:0] a;
    logic [OUT_W-1:0] b;
  } lab_t;

  lab_t            lab_expected_q[$];
  logic [CH_W-1:0] wx, wy, wz;
  longint          cube_rom[TABLE_ENTRIES];

  // Integer cube root, done here rather than borrowed from the package.
  function automatic longint unsigned root3(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lane_value(longint unsigned c, logic [CH_W-1:0] w);
    longint unsigned dv, pos, idx;
    longint frac, diff;
    dv  = (w == 0) ? 1 : w;
    pos = ((longint'(TABLE_ENTRIES) * c) << 16) / dv;
    idx = pos >> 16;
    if (idx > TABLE_ENTRIES - 2) idx = TABLE_ENTRIES - 2;
    frac = pos - (idx << 16);
    diff = cube_rom[idx+1] - cube_rom[idx];
    if (diff > 16384) diff = 16384;
    if (diff < -16384) diff = -16384;
    return cube_rom[idx] + floor_sh(frac * diff, 16);
  endfunction

  function automatic logic [OUT_W-1:0] round_sat(longint q16);
    longint v;
    v = floor_sh(q16 + 128, 8);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[OUT_W-1:0];
  endfunction

  function automatic lab_t convert_pixel(logic [CH_W-1:0] x, logic [CH_W-1:0] y,
                                         logic [CH_W-1:0] z);
    longint fx, fy, fz;
    lab_t r;
    fx  = lane_value(x, wx);
    fy  = lane_value(y, wy);
    fz  = lane_value(z, wz);
    r.l = round_sat(116 * fy - 16 * 65536);
    r.a = round_sat(500 * (fx - fy));
    r.b = round_sat(200 * (fy - fz));
    return r;
  endfunction

  initial begin
    longint unsigned n;
    n = TABLE_ENTRIES;
    for (longint unsigned i = 0; i < n; i++) begin
      if (i * 1000000 < 8856 * n)
        cube_rom[i] = ((903292 * i + 16000 * n) * 65536 + 58000 * n) / (116000 * n);
      else
        cube_rom[i] = root3((i << 48) / n);
    end
  end

  assign pending_o = lab_expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    lab_t e;
    if (!rst_ni) begin
      wx <= WHITE_X_RST;
      wy <= WHITE_Y_RST;
      wz <= WHITE_Z_RST;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WHITE_X: wx <= cfg_data_i;
          REG_WHITE_Y: wy <= cfg_data_i;
          REG_WHITE_Z: wz <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        lab_expected_q.push_back(convert_pixel(x_in_i, y_in_i, z_in_i));
      if (out_valid_i && !out_stall_i) begin
        if (lab_expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result L=%0d a=%0d b=%0d",
                                          l_out_i, a_out_i, b_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = lab_expected_q.pop_front();
          if (e.l !== l_out_i || e.a !== a_out_i || e.b !== b_out_i) begin
            if (fail_count_o < 10)
              $display("Mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                       $signed(e.l), $signed(e.a), $signed(e.b),
                       l_out_i, a_out_i, b_out_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_xyz_to_lab_converter_unit.sv =====
module tb_xyz_to_lab_converter_unit;
  import xlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CH_W-1:0]         x_in_i = '0;
  logic [CH_W-1:0]         y_in_i = '0;
  logic [CH_W-1:0]         z_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] l_out_o, a_out_o, b_out_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CH_W-1:0]         cfg_data_i = '0;
  int                      fail_count;
  int                      pending;

  // Idle rates in percent for the sender and the receiver; changed per phase.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  // When set, the receiver holds its stall high regardless of the idle rate.
  bit  hold_receiver = 1'b0;

  always #6 clk_i = ~clk_i;

  xyz_to_lab_converter_unit u_dut (.*);

  tb_xyz_to_lab_converter_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .x_in_i, .y_in_i, .z_in_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .l_out_i(l_out_o), .a_out_i(a_out_o), .b_out_i(b_out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random each cycle, or steadily during a hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
  end

  // Sends one pixel. The sender may idle first; once valid is raised the
  // payload stays put until the transaction completes.
  task automatic send_pixel(input logic [CH_W-1:0] x, input logic [CH_W-1:0] y,
                            input logic [CH_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_in_i <= x;
    y_in_i <= y;
    z_in_i <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid after the last pixel of a burst.
  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result has come back and the pipeline is empty.
  task automatic drain();
    stop_sending();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Presents one register write and waits for its transaction; the caller
  // drops valid after the last write.
  task automatic write_white(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_white(input logic [CH_W-1:0] x, input logic [CH_W-1:0] y,
                           input logic [CH_W-1:0] z);
    write_white(REG_WHITE_X, x);
    write_white(REG_WHITE_Y, y);
    write_white(REG_WHITE_Z, z);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly values below the white point, where the table is interpolated,
  // with some spread over the whole range so that extrapolation shows up.
  function automatic logic [CH_W-1:0] pick_channel(input logic [CH_W-1:0] w);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return CH_W'($urandom_range((w == 0) ? 1 : w));
    if (r < 7) return CH_W'($urandom_range(15));
    return CH_W'($urandom);
  endfunction

  task automatic random_burst(input int count, input logic [CH_W-1:0] wx,
                              input logic [CH_W-1:0] wy, input logic [CH_W-1:0] wz);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_channel(wx), pick_channel(wy), pick_channel(wz));
    end
  endtask

  initial begin
    logic [CH_W-1:0] wx, wy, wz;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels under the D65 white: black, full scale, the whites
    // themselves, single channels at the extremes and points near the knee
    // of the linear segment.
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
    send_pixel(16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd215, 16'd226, 16'd247);
    send_pixel(16'd216, 16'd227, 16'd248);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // Smallest whites and a white of zero, which acts as one: every channel
    // above one lies far beyond the white, so results extrapolate and saturate.
    set_white(16'd0, 16'd1, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF, 16'd0);
    drain();

    // Largest whites: the channels never exceed the white point.
    set_white(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd1, 16'd2, 16'd3);
    drain();

    // Random phases. The receiver idles more in the first, the sender in the
    // second, and neither in the last; each phase runs two bursts, each with its own white.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < 2; s++) begin
        wx = (s == 0 && ph == 0) ? WHITE_X_RST : CH_W'($urandom_range(65535, 1));
        wy = (s == 0 && ph == 0) ? WHITE_Y_RST : CH_W'($urandom_range(65535, 1));
        wz = (s == 0 && ph == 0) ? WHITE_Z_RST : CH_W'($urandom_range(65535, 1));
        if (ph == 2 && s == 1) begin
          wx = 16'h8000; wy = 16'h0100; wz = 16'h00FF;
        end
        set_white(wx, wy, wz);
        random_burst(235, wx, wy, wz);
        drain();
      end
    end

    // Long receiver hold-off while the sender keeps offering pixels. The
    // burst is longer than the pipeline, so the pipeline fills and the input
    // channel stalls.
    fork
      begin
        hold_receiver <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_receiver <= 1'b0;
      end
      random_burst(120, wx, wy, wz);
    join
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
